FILE: sv/sctne_pkg.sv
// Shared codes and control/status types of the shape cost table.
package sctne_pkg;

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_TOTAL  = 2'd1;
	localparam logic [1:0] MODE_UPLOAD = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [1:0] KIND_MISS  = 2'd0;
	localparam logic [1:0] KIND_EXACT = 2'd1;
	localparam logic [1:0] KIND_NEAR  = 2'd2;

	localparam logic [3:0] MOP_RI_Q = 4'd0;
	localparam logic [3:0] MOP_WANT = 4'd1;
	localparam logic [3:0] MOP_RI_R = 4'd2;
	localparam logic [3:0] MOP_HAVE = 4'd3;
	localparam logic [3:0] MOP_X1   = 4'd4;
	localparam logic [3:0] MOP_X2   = 4'd5;
	localparam logic [3:0] MOP_ARR  = 4'd6;
	localparam logic [3:0] MOP_NC   = 4'd7;
	localparam logic [3:0] MOP_RC   = 4'd8;
	localparam logic [3:0] MOP_IC   = 4'd9;
	localparam logic [3:0] MOP_UPL  = 4'd10;

	localparam logic [2:0] SV_NONE     = 3'd0;
	localparam logic [2:0] SV_WANT     = 3'd1;
	localparam logic [2:0] SV_HAVE     = 3'd2;
	localparam logic [2:0] SV_TMP      = 3'd3;
	localparam logic [2:0] SV_ACC      = 3'd4;
	localparam logic [2:0] SV_ACC_ADD  = 3'd5;
	localparam logic [2:0] SV_ACC_ADD4 = 3'd6;

	localparam logic [1:0] TS_ZERO  = 2'd0;
	localparam logic [1:0] TS_TOTAL = 2'd1;
	localparam logic [1:0] TS_NEAR  = 2'd2;
	localparam logic [1:0] TS_QUOT  = 2'd3;

	typedef struct packed {
		logic       latch;
		logic       append_wr;
		logic       mul_go;
		logic [3:0] mul_op;
		logic [2:0] save;
		logic       div_go;
		logic       div_upl;
		logic       rd_go;
		logic       rd_best;
		logic       take_best;
		logic       idx_clr;
		logic       idx_inc;
		logic       res_ld;
		logic [1:0] res_status;
		logic [1:0] res_kind;
		logic [1:0] res_tsel;
	} sctne_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       app_bad;
		logic       q_bad;
		logic       full;
		logic       cnt_zero;
		logic       idx_last;
		logic       fmatch;
		logic       exact;
		logic       class_ok;
		logic       better;
		logic       upl_known;
		logic       mul_busy;
		logic       div_busy;
		logic       out_free;
	} sctne_sts_t;

endpackage

FILE: sv/sctne_ram.sv
// Generic single-port-write, registered-read RAM.
module sctne_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                     wr_data,
	input  logic                                 rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: sv/sctne_datapath.sv
// Datapath: input latch, record table, shared multiplier, divider and result register.
module sctne_datapath #(
	parameter int TABLE_DEPTH = 64,
	parameter int DIM_BITS    = 16,
	parameter int TIME_BITS   = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sctne_pkg::sctne_cmd_t  cmd,
	output sctne_pkg::sctne_sts_t  sts,
	input  logic [1:0]             in_user,
	input  logic [223:0]           in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [55:0]            out_data
);
	import sctne_pkg::*;

	localparam int D  = DIM_BITS;
	localparam int T  = TIME_BITS;
	localparam int M  = 3 * D;
	localparam int AW = (M > T) ? M : T;
	localparam int PW = AW + M;
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = $clog2(PW + 1);

	typedef struct packed {
		logic         uk;
		logic [T-1:0] upl;
		logic         fk;
		logic [T-1:0] fix;
		logic [T-1:0] tot;
		logic [7:0]   fmt;
		logic [D-1:0] cols;
		logic [D-1:0] inner;
		logic [D-1:0] rows;
		logic [1:0]   eng;
	} rec_t;

	localparam int RW = $bits(rec_t);

	logic [1:0]   mode_q;
	logic [1:0]   eng_q;
	logic [D-1:0] rows_q, inner_q, cols_q;
	logic [7:0]   fmt_q;
	logic         it_nz_q;
	logic [T-1:0] tot_q, fix_q, upl_q;
	logic         fk_q, uk_q;

	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q, best_idx_q;
	logic [M-1:0]  want_q, have_q, best_hi_q, best_lo_q, best_have_q, acc_q;
	logic [PW-1:0] tmp_q;
	logic [PW-1:0] ma_q, mp_q;
	logic [M-1:0]  mb_q;
	logic [PW-1:0] dn_q, dq_q;
	logic [M-1:0]  dd_q, dr_q;
	logic [NW-1:0] dcnt_q;

	logic          out_valid_q;
	logic [55:0]   out_data_q;

	rec_t          rec, wr_rec;
	logic [RW-1:0] rd_raw;

	logic [M-1:0]  hi, lo;
	logic          want_ge;
	logic [PW-1:0] op_a;
	logic [M-1:0]  op_b;
	logic [PW+7:0] pp;
	logic [M:0]    dtrial;
	logic          dge;
	logic [T-1:0]  fxc, arr, sq, near, tsel;
	logic [T:0]    nsum;

	assign wr_rec = '{uk: uk_q, upl: upl_q, fk: fk_q, fix: fix_q, tot: tot_q, fmt: fmt_q,
		cols: cols_q, inner: inner_q, rows: rows_q, eng: eng_q};
	assign rec = rec_t'(rd_raw);

	sctne_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (cmd.append_wr),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (wr_rec),
		.rd_en   (cmd.rd_go | cmd.rd_best),
		.rd_addr (cmd.rd_best ? best_idx_q : idx_q),
		.rd_data (rd_raw)
	);

	always_comb begin
		want_ge = want_q >= have_q;
		hi = want_ge ? want_q : have_q;
		lo = want_ge ? have_q : want_q;
		fxc = rec.fk ? rec.fix : '0;
		if (fxc > rec.tot) begin
			fxc = rec.tot;
		end
		arr = rec.tot - fxc;
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.mul_op)
			MOP_RI_Q: begin op_a = PW'(rows_q);    op_b = M'(inner_q);  end
			MOP_WANT: begin op_a = mp_q;           op_b = M'(cols_q);   end
			MOP_RI_R: begin op_a = PW'(rec.rows);  op_b = M'(rec.inner); end
			MOP_HAVE: begin op_a = mp_q;           op_b = M'(rec.cols); end
			MOP_X1:   begin op_a = PW'(hi);        op_b = best_lo_q;    end
			MOP_X2:   begin op_a = PW'(best_hi_q); op_b = lo;           end
			MOP_ARR:  begin op_a = PW'(arr);       op_b = want_q;       end
			MOP_NC:   begin op_a = PW'(rec.inner); op_b = M'(rec.cols); end
			MOP_RC:   begin op_a = PW'(rec.rows);  op_b = M'(rec.cols); end
			MOP_IC:   begin op_a = PW'(inner_q);   op_b = M'(cols_q);   end
			MOP_UPL:  begin op_a = PW'(rec.upl);   op_b = mp_q[M-1:0];  end
			default:  begin op_a = '0;             op_b = '0;           end
		endcase
	end

	assign pp = ma_q * mb_q[7:0];
	assign dtrial = {dr_q, dn_q[PW-1]};
	assign dge = dtrial >= {1'b0, dd_q};

	always_comb begin
		sq = (|dq_q[PW-1:T]) ? '1 : dq_q[T-1:0];
		nsum = {1'b0, fxc} + {1'b0, sq};
		near = nsum[T] ? '1 : nsum[T-1:0];
		case (cmd.res_tsel)
			TS_TOTAL: tsel = rec.tot;
			TS_NEAR:  tsel = near;
			TS_QUOT:  tsel = sq;
			default:  tsel = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q  <= in_user;
			eng_q   <= in_data[1:0];
			rows_q  <= D'(in_data[17:2]);
			inner_q <= D'(in_data[33:18]);
			cols_q  <= D'(in_data[49:34]);
			fmt_q   <= in_data[57:50];
			it_nz_q <= |in_data[73:58];
			tot_q   <= T'(in_data[121:74]);
			fix_q   <= T'(in_data[169:122]);
			fk_q    <= in_data[170];
			upl_q   <= T'(in_data[218:171]);
			uk_q    <= in_data[219];
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
		if (cmd.take_best) begin
			best_idx_q  <= idx_q;
			best_hi_q   <= hi;
			best_lo_q   <= lo;
			best_have_q <= have_q;
		end
		case (cmd.save)
			SV_WANT:     want_q <= mp_q[M-1:0];
			SV_HAVE:     have_q <= mp_q[M-1:0];
			SV_TMP:      tmp_q  <= mp_q;
			SV_ACC:      acc_q  <= mp_q[M-1:0];
			SV_ACC_ADD:  acc_q  <= acc_q + mp_q[M-1:0];
			SV_ACC_ADD4: acc_q  <= acc_q + (mp_q[M-1:0] << 2);
			default: ;
		endcase
		if (cmd.div_go) begin
			dn_q <= mp_q;
			dd_q <= cmd.div_upl ? acc_q : best_have_q;
			dr_q <= '0;
			dq_q <= '0;
		end else if (dcnt_q != '0) begin
			dr_q <= dge ? M'(dtrial - {1'b0, dd_q}) : dtrial[M-1:0];
			dn_q <= dn_q << 1;
			dq_q <= {dq_q[PW-2:0], dge};
		end
		if (cmd.res_ld) begin
			out_data_q <= {4'b0, 48'(tsel), cmd.res_kind, cmd.res_status};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
			ma_q        <= '0;
			mb_q        <= '0;
			mp_q        <= '0;
		end else begin
			if (cmd.append_wr) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.div_go) begin
				dcnt_q <= NW'(PW);
			end else if (dcnt_q != '0) begin
				dcnt_q <= dcnt_q - NW'(1);
			end
			if (cmd.mul_go) begin
				ma_q <= op_a;
				mb_q <= op_b;
				mp_q <= '0;
			end else if (mb_q != '0) begin
				mp_q <= mp_q + pp[PW-1:0];
				ma_q <= ma_q << 8;
				mb_q <= mb_q >> 8;
			end
			if (cmd.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.mode      = mode_q;
		sts.app_bad   = (eng_q == 2'd0) || (rows_q == '0) || (inner_q == '0) ||
			(cols_q == '0) || !it_nz_q;
		sts.q_bad     = (mode_q == 2'd3) || (rows_q == '0) || (inner_q == '0) ||
			(cols_q == '0);
		sts.full      = count_q == CW'(TABLE_DEPTH);
		sts.cnt_zero  = count_q == '0;
		sts.idx_last  = (CW'(idx_q) + CW'(1)) == count_q;
		sts.fmatch    = (rec.eng == eng_q) && (rec.fmt == fmt_q);
		sts.exact     = (rec.rows == rows_q) && (rec.inner == inner_q) && (rec.cols == cols_q);
		sts.class_ok  = (rec.rows > D'(1)) == (rows_q > D'(1));
		sts.better    = tmp_q < mp_q;
		sts.upl_known = rec.uk;
		sts.mul_busy  = mb_q != '0;
		sts.div_busy  = dcnt_q != '0;
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: sv/sctne_ctrl.sv
// Controller: sequences appends, the table scan and the final estimate.
module sctne_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sctne_pkg::sctne_sts_t sts,
	output sctne_pkg::sctne_cmd_t cmd
);
	import sctne_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DEC  = 5'd1;
	localparam logic [4:0] S_W1   = 5'd2;
	localparam logic [4:0] S_W2   = 5'd3;
	localparam logic [4:0] S_RD   = 5'd4;
	localparam logic [4:0] S_CHK  = 5'd5;
	localparam logic [4:0] S_H1   = 5'd6;
	localparam logic [4:0] S_H2   = 5'd7;
	localparam logic [4:0] S_CMPX = 5'd8;
	localparam logic [4:0] S_X1   = 5'd9;
	localparam logic [4:0] S_X2   = 5'd10;
	localparam logic [4:0] S_NXT  = 5'd11;
	localparam logic [4:0] S_FIN  = 5'd12;
	localparam logic [4:0] S_FRD  = 5'd13;
	localparam logic [4:0] S_T1   = 5'd14;
	localparam logic [4:0] S_T2   = 5'd15;
	localparam logic [4:0] S_U1   = 5'd16;
	localparam logic [4:0] S_U2   = 5'd17;
	localparam logic [4:0] S_U3   = 5'd18;
	localparam logic [4:0] S_U4   = 5'd19;
	localparam logic [4:0] S_U5   = 5'd20;
	localparam logic [4:0] S_U6   = 5'd21;
	localparam logic [4:0] S_DONE = 5'd22;

	logic [4:0] state_q, state_d;
	logic [1:0] kind_q, kind_d;
	logic [1:0] rs_status_q, rs_status_d, rs_kind_q, rs_kind_d, rs_tsel_q, rs_tsel_d;

	always_comb begin
		state_d     = state_q;
		kind_d      = kind_q;
		rs_status_d = rs_status_q;
		rs_kind_d   = rs_kind_q;
		rs_tsel_d   = rs_tsel_q;
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
				kind_d    = KIND_MISS;
				if (in_valid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				rs_kind_d = KIND_MISS;
				rs_tsel_d = TS_ZERO;
				if (sts.mode == MODE_APPEND) begin
					state_d = S_DONE;
					if (sts.app_bad) begin
						rs_status_d = ST_INVALID;
					end else if (sts.full) begin
						rs_status_d = ST_FULL;
					end else begin
						rs_status_d   = ST_OK;
						cmd.append_wr = 1'b1;
					end
				end else if (sts.q_bad) begin
					rs_status_d = ST_INVALID;
					state_d     = S_DONE;
				end else begin
					rs_status_d = ST_OK;
					cmd.mul_go  = 1'b1;
					cmd.mul_op  = MOP_RI_Q;
					state_d     = S_W1;
				end
			end
			S_W1: begin
				if (!sts.mul_busy) begin
					cmd.mul_go = 1'b1;
					cmd.mul_op = MOP_WANT;
					state_d    = S_W2;
				end
			end
			S_W2: begin
				if (!sts.mul_busy) begin
					cmd.save    = SV_WANT;
					cmd.idx_clr = 1'b1;
					state_d     = sts.cnt_zero ? S_FIN : S_RD;
				end
			end
			S_RD: begin
				cmd.rd_go = 1'b1;
				state_d   = S_CHK;
			end
			S_CHK: begin
				if (!sts.fmatch) begin
					state_d = S_NXT;
				end else if (sts.exact) begin
					kind_d        = KIND_EXACT;
					cmd.take_best = 1'b1;
					state_d       = S_FIN;
				end else if (!sts.class_ok) begin
					state_d = S_NXT;
				end else begin
					cmd.mul_go = 1'b1;
					cmd.mul_op = MOP_RI_R;
					state_d    = S_H1;
				end
			end
			S_H1: begin
				if (!sts.mul_busy) begin
					cmd.mul_go = 1'b1;
					cmd.mul_op = MOP_HAVE;
					state_d    = S_H2;
				end
			end
			S_H2: begin
				if (!sts.mul_busy) begin
					cmd.save = SV_HAVE;
					state_d  = S_CMPX;
				end
			end
			S_CMPX: begin
				if (kind_q == KIND_MISS) begin
					kind_d        = KIND_NEAR;
					cmd.take_best = 1'b1;
					state_d       = S_NXT;
				end else begin
					cmd.mul_go = 1'b1;
					cmd.mul_op = MOP_X1;
					state_d    = S_X1;
				end
			end
			S_X1: begin
				if (!sts.mul_busy) begin
					cmd.save   = SV_TMP;
					cmd.mul_go = 1'b1;
					cmd.mul_op = MOP_X2;
					state_d    = S_X2;
				end
			end
			S_X2: begin
				if (!sts.mul_busy) begin
					cmd.take_best = sts.better;
					state_d       = S_NXT;
				end
			end
			S_NXT: begin
				if (sts.idx_last) begin
					state_d = S_FIN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			S_FIN: begin
				if (kind_q == KIND_MISS) begin
					state_d = S_DONE;
				end else begin
					cmd.rd_best = 1'b1;
					state_d     = S_FRD;
				end
			end
			S_FRD: begin
				rs_kind_d = kind_q;
				if (sts.mode == MODE_TOTAL) begin
					if (kind_q == KIND_EXACT) begin
						rs_tsel_d = TS_TOTAL;
						state_d   = S_DONE;
					end else begin
						cmd.mul_go = 1'b1;
						cmd.mul_op = MOP_ARR;
						state_d    = S_T1;
					end
				end else if (!sts.upl_known) begin
					state_d = S_DONE;
				end else begin
					cmd.mul_go = 1'b1;
					cmd.mul_op = MOP_RI_R;
					state_d    = S_U1;
				end
			end
			S_T1: begin
				if (!sts.mul_busy) begin
					cmd.div_go = 1'b1;
					state_d    = S_T2;
				end
			end
			S_T2: begin
				if (!sts.div_busy) begin
					rs_tsel_d = TS_NEAR;
					state_d   = S_DONE;
				end
			end
			S_U1: begin
				if (!sts.mul_busy) begin
					cmd.save   = SV_ACC;
					cmd.mul_go = 1'b1;
					cmd.mul_op = MOP_NC;
					state_d    = S_U2;
				end
			end
			S_U2: begin
				if (!sts.mul_busy) begin
					cmd.save   = SV_ACC_ADD;
					cmd.mul_go = 1'b1;
					cmd.mul_op = MOP_RC;
					state_d    = S_U3;
				end
			end
			S_U3: begin
				if (!sts.mul_busy) begin
					cmd.save   = SV_ACC_ADD4;
					cmd.mul_go = 1'b1;
					cmd.mul_op = MOP_IC;
					state_d    = S_U4;
				end
			end
			S_U4: begin
				if (!sts.mul_busy) begin
					cmd.mul_go = 1'b1;
					cmd.mul_op = MOP_UPL;
					state_d    = S_U5;
				end
			end
			S_U5: begin
				if (!sts.mul_busy) begin
					cmd.div_go  = 1'b1;
					cmd.div_upl = 1'b1;
					state_d     = S_U6;
				end
			end
			S_U6: begin
				if (!sts.div_busy) begin
					rs_tsel_d = TS_QUOT;
					state_d   = S_DONE;
				end
			end
			S_DONE: begin
				cmd.res_status = rs_status_q;
				cmd.res_kind   = rs_kind_q;
				cmd.res_tsel   = rs_tsel_q;
				if (sts.out_free) begin
					cmd.res_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= KIND_MISS;
			rs_status_q <= ST_OK;
			rs_kind_q   <= KIND_MISS;
			rs_tsel_q   <= TS_ZERO;
		end else begin
			state_q     <= state_d;
			kind_q      <= kind_d;
			rs_status_q <= rs_status_d;
			rs_kind_q   <= rs_kind_d;
			rs_tsel_q   <= rs_tsel_d;
		end
	end

endmodule

FILE: sv/shape_cost_table_nearest_estimate.sv
// Top level of the shape cost table with nearest-record estimation.
//
//  channel  | direction | payload
//  s_axis   | in        | tuser: mode; tdata: append or query fields
//  m_axis   | out       | tdata: status, match_kind, time_estimate
//
// A query computes its MAC count with the shared 8-bit-digit multiplier,
// then reads the records one at a time; a record of the same class costs
// up to four multiplies. The final estimate adds up to five multiplies and
// a one-bit-per-cycle divide. Reset clears the table count; a finished item
// waits in the output register while the next item is taken.
module shape_cost_table_nearest_estimate #(
	parameter int TABLE_DEPTH = 64,
	parameter int DIM_BITS    = 16,
	parameter int TIME_BITS   = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata from bit 0: engine, rows, inner, cols, format, iterations, total_time,
	// fixed_time, fixed_known, upload_time, upload_known, zero fill.
	input  logic [223:0] s_axis_tdata,
	// tuser: mode.
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata from bit 0: status, match_kind, time_estimate, zero fill.
	output logic [55:0]  m_axis_tdata
);
	import sctne_pkg::*;

	sctne_cmd_t cmd;
	sctne_sts_t sts;

	sctne_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.DIM_BITS    (DIM_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_user   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	sctne_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("block took a second item while busy");

	a_append_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append_wr |-> !sts.full)
		else $error("append written to a full table");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_ld |-> sts.out_free)
		else $error("result overwrote an item not yet taken");

	a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_go |-> !sts.mul_busy)
		else $error("multiply started while the multiplier was busy");

endmodule

FILE: tb/shape_cost_table_nearest_estimate_tb.sv
// Self-checking testbench for the shape cost table: a directed table, then random traffic.
`timescale 1ns / 100ps

module shape_cost_table_nearest_estimate_tb;
	import sctne_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  engine;
		logic [15:0] rows;
		logic [15:0] inner;
		logic [15:0] cols;
		logic [7:0]  format;
		logic [15:0] iterations;
		logic [47:0] total_time;
		logic [47:0] fixed_time;
		logic        fixed_known;
		logic [47:0] upload_time;
		logic        upload_known;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  kind;
		logic [47:0] estimate;
	} answer_t;

	typedef struct {
		req_t    req;
		logic    typed;
		answer_t ans;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [223:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;

	int errors = 0;
	int quiet = 0;
	int out_wait = 0;
	answer_t pending_answers[$];

	int tab_count;
	req_t tab[DEPTH];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	shape_cost_table_nearest_estimate u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic logic [47:0] sat48(logic [191:0] v);
		return (v > {144'd0, TMAX}) ? TMAX : v[47:0];
	endfunction

	function automatic logic [191:0] macs(logic [15:0] r, logic [15:0] i, logic [15:0] c);
		logic [191:0] p;
		p = 192'(r) * 192'(i);
		return p * 192'(c);
	endfunction

	function automatic answer_t estimate_cost(req_t q);
		answer_t a;
		int best, kind;
		logic [191:0] want, have, hi, lo, bhi, blo, num;
		logic [47:0] fx, scaled;
		a = '0;
		best = 0;
		kind = 0;
		bhi = '0;
		blo = '0;
		if (q.mode == MODE_APPEND) begin
			if (q.engine == 0 || q.rows == 0 || q.inner == 0 || q.cols == 0 ||
			    q.iterations == 0)
				a.status = ST_INVALID;
			else if (tab_count >= DEPTH)
				a.status = ST_FULL;
			else begin
				tab[tab_count] = q;
				tab_count++;
			end
			return a;
		end
		if (q.mode > MODE_UPLOAD || q.rows == 0 || q.inner == 0 || q.cols == 0) begin
			a.status = ST_INVALID;
			return a;
		end
		want = macs(q.rows, q.inner, q.cols);
		for (int k = 0; k < tab_count; k++) begin
			if (tab[k].engine != q.engine || tab[k].format != q.format) continue;
			if (tab[k].rows == q.rows && tab[k].inner == q.inner && tab[k].cols == q.cols) begin
				best = k;
				kind = 1;
				break;
			end
			if ((tab[k].rows > 1) != (q.rows > 1)) continue;
			have = macs(tab[k].rows, tab[k].inner, tab[k].cols);
			if (want >= have) begin
				hi = want;
				lo = have;
			end else begin
				hi = have;
				lo = want;
			end
			if (kind == 0 || hi * blo < bhi * lo) begin
				best = k;
				kind = 2;
				bhi = hi;
				blo = lo;
			end
		end
		if (kind == 0) return a;
		a.kind = kind[1:0];
		if (q.mode == MODE_TOTAL) begin
			if (kind == 1)
				a.estimate = tab[best].total_time;
			else begin
				fx = tab[best].fixed_known ? tab[best].fixed_time : 48'd0;
				if (fx > tab[best].total_time) fx = tab[best].total_time;
				have = macs(tab[best].rows, tab[best].inner, tab[best].cols);
				num = 192'(tab[best].total_time - fx) * want;
				scaled = sat48(num / have);
				a.estimate = (scaled > TMAX - fx) ? TMAX : fx + scaled;
			end
		end else if (tab[best].upload_known) begin
			hi = 192'(tab[best].rows) * 192'(tab[best].inner) +
			     192'(tab[best].inner) * 192'(tab[best].cols) +
			     192'd4 * 192'(tab[best].rows) * 192'(tab[best].cols);
			num = 192'(tab[best].upload_time) * (192'(q.inner) * 192'(q.cols));
			a.estimate = sat48(num / hi);
		end
		return a;
	endfunction

	task automatic send_item(req_t q);
		int gap;
		gap = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= q.mode;
		s_axis_tdata <= {4'b0, q.upload_known, q.upload_time, q.fixed_known, q.fixed_time,
			q.total_time, q.iterations, q.format, q.cols, q.inner, q.rows, q.engine};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic run_row(row_t r);
		answer_t a;
		a = estimate_cost(r.req);
		if (r.typed && a != r.ans) begin
			$error("directed row disagrees with predictor: %h vs %h", r.ans, a);
			errors++;
		end
		pending_answers.push_back(a);
		send_item(r.req);
	endtask

	function automatic req_t rand_req(bit well_formed);
		req_t q;
		logic [15:0] dims[3];
		q = '0;
		q.mode = (well_formed || $urandom_range(0, 3) != 0) ? 2'($urandom_range(0, 2)) :
			2'($urandom_range(0, 3));
		q.engine = 2'($urandom_range(well_formed ? 1 : 0, 3));
		q.format = 8'($urandom_range(0, 2));
		for (int k = 0; k < 3; k++)
			case ($urandom_range(0, 5))
				0: dims[k] = 16'd1;
				1: dims[k] = 16'($urandom);
				2: dims[k] = well_formed ? 16'hFFFF : 16'd0;
				default: dims[k] = 16'($urandom_range(1, 8));
			endcase
		q.rows = dims[0];
		q.inner = dims[1];
		q.cols = dims[2];
		q.iterations = (!well_formed && $urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
		q.total_time = $urandom_range(0, 1) ? 48'({$urandom, $urandom}) : 48'($urandom_range(0, 99999));
		q.fixed_time = $urandom_range(0, 1) ? 48'({$urandom, $urandom}) : q.total_time >> 2;
		q.upload_time = $urandom_range(0, 1) ? 48'({$urandom, $urandom}) : 48'($urandom_range(0, 9999));
		q.fixed_known = 1'($urandom);
		q.upload_known = 1'($urandom);
		return q;
	endfunction

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			answer_t got, exp_a;
			got.status = m_axis_tdata[1:0];
			got.kind = m_axis_tdata[3:2];
			got.estimate = m_axis_tdata[51:4];
			if (pending_answers.size() == 0) begin
				$error("unexpected result item %h", got);
				errors++;
			end else begin
				exp_a = pending_answers.pop_front();
				if (got.status != exp_a.status) begin
					$error("status exp %0d got %0d", exp_a.status, got.status);
					errors++;
				end
				if (got.kind != exp_a.kind) begin
					$error("match_kind exp %0d got %0d", exp_a.kind, got.kind);
					errors++;
				end
				if (got.estimate != exp_a.estimate) begin
					$error("time_estimate exp %0d got %0d", exp_a.estimate, got.estimate);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		int w;
		if (m_axis_tvalid && m_axis_tready) begin
			w = $urandom_range(0, 14);
			out_wait <= w;
			m_axis_tready <= (w == 0);
		end else if (out_wait > 0) begin
			out_wait <= out_wait - 1;
			m_axis_tready <= (out_wait == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		row_t rows_dir[$];
		row_t r;
		req_t q;
		tab_count = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		q = '0; q.mode = MODE_TOTAL; q.engine = 2'd1; q.rows = 16'd4; q.inner = 16'd4; q.cols = 16'd4;
		r.req = q; r.typed = 1; r.ans = '{ST_OK, KIND_MISS, 48'd0}; rows_dir.push_back(r);
		q.mode = MODE_APPEND; q.iterations = 16'd0;
		r.req = q; r.ans = '{ST_INVALID, KIND_MISS, 48'd0}; rows_dir.push_back(r);
		q.iterations = 16'd1; q.engine = 2'd0;
		r.req = q; rows_dir.push_back(r);
		q.engine = 2'd1; q.cols = 16'd0;
		r.req = q; rows_dir.push_back(r);
		q.mode = 2'd3; q.cols = 16'd4;
		r.req = q; rows_dir.push_back(r);
		q.mode = MODE_UPLOAD; q.rows = 16'd0;
		r.req = q; rows_dir.push_back(r);
		q = '0; q.mode = MODE_APPEND; q.engine = 2'd1; q.rows = 16'd4; q.inner = 16'd4;
		q.cols = 16'd4; q.iterations = 16'hFFFF; q.total_time = 48'd1000; q.fixed_time = 48'd200;
		q.fixed_known = 1; q.upload_time = 48'd480; q.upload_known = 1;
		r.req = q; r.ans = '{ST_OK, KIND_MISS, 48'd0}; rows_dir.push_back(r);
		q.mode = MODE_TOTAL;
		r.req = q; r.ans = '{ST_OK, KIND_EXACT, 48'd1000}; rows_dir.push_back(r);
		r.typed = 0;
		q.mode = MODE_UPLOAD; r.req = q; rows_dir.push_back(r);
		q.mode = MODE_TOTAL; q.cols = 16'hFFFF; q.inner = 16'hFFFF; r.req = q; rows_dir.push_back(r);
		q.mode = MODE_UPLOAD; r.req = q; rows_dir.push_back(r);
		q.mode = MODE_TOTAL; q.rows = 16'd1; r.req = q; rows_dir.push_back(r);
		q.mode = MODE_APPEND; q.total_time = TMAX; q.fixed_time = TMAX; q.fixed_known = 0;
		q.upload_time = TMAX; q.upload_known = 0; q.rows = 16'hFFFF; q.engine = 2'd3;
		q.format = 8'hFF; r.req = q; rows_dir.push_back(r);
		q.mode = MODE_TOTAL; q.cols = 16'd1; r.req = q; rows_dir.push_back(r);
		q.mode = MODE_UPLOAD; r.req = q; rows_dir.push_back(r);
		q.mode = MODE_TOTAL; q.engine = 2'd0; r.req = q; rows_dir.push_back(r);

		foreach (rows_dir[k]) run_row(rows_dir[k]);

		for (int n = 0; n < 650; n++) begin
			// Early on, mostly appends so the table fills and then reports full.
			r.req = rand_req($urandom_range(0, 4) != 0);
			if (n < 150 && $urandom_range(0, 1)) r.req.mode = MODE_APPEND;
			r.typed = 0;
			run_row(r);
		end
		s_axis_tvalid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
